// File: src/rpn_pkg.sv
package rpn_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int WORD_W      = 32;
  localparam int DEPTH_OUT_W = 5;
  localparam int DEXT_W      = CNT_W + DEPTH_OUT_W;
  localparam int DIV_CNT_W   = $clog2(WORD_W);

  typedef logic [2:0]        func_t;
  typedef logic [1:0]        err_t;
  typedef logic [WORD_W-1:0] word_t;

  localparam func_t FN_PUSH = 3'd0;
  localparam func_t FN_ADD  = 3'd1;
  localparam func_t FN_SUB  = 3'd2;
  localparam func_t FN_MUL  = 3'd3;
  localparam func_t FN_DIV  = 3'd4;

  localparam err_t ERR_NONE      = 2'd0;
  localparam err_t ERR_OVERFLOW  = 2'd1;
  localparam err_t ERR_UNDERFLOW = 2'd2;
  localparam err_t ERR_DIVZERO   = 2'd3;

  typedef struct packed {
    logic load_tok;
    logic push;
    logic set_err;
    err_t err_code;
    logic alu_load;
    logic div_start;
    logic div_load;
    logic commit;
    logic out_load;
  } rpn_cmd_t;

  typedef struct packed {
    logic err_nz;
    logic fn_push;
    logic fn_op;
    logic fn_div;
    logic full;
    logic under;
    logic divisor_zero;
    logic div_done;
  } rpn_sts_t;

endpackage

// File: src/rpn_ctrl.sv
module rpn_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rpn_pkg::rpn_sts_t sts,
  output rpn_pkg::rpn_cmd_t cmd
);
  import rpn_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_OPERAND = 3'd2;
  localparam logic [2:0] S_DIVIDE  = 3'd3;
  localparam logic [2:0] S_COMMIT  = 3'd4;
  localparam logic [2:0] S_RESULT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_tok = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_RESULT;
        if (!sts.err_nz) begin
          if (sts.fn_push) begin
            if (sts.full) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = ERR_OVERFLOW;
            end else begin
              cmd.push = 1'b1;
            end
          end else if (sts.fn_op) begin
            if (sts.under) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = ERR_UNDERFLOW;
            end else begin
              state_nxt = S_OPERAND;
            end
          end
        end
      end
      S_OPERAND: begin
        if (sts.fn_div) begin
          if (sts.divisor_zero) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ERR_DIVZERO;
            state_nxt    = S_RESULT;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIVIDE;
          end
        end else begin
          cmd.alu_load = 1'b1;
          state_nxt    = S_COMMIT;
        end
      end
      S_DIVIDE: begin
        if (sts.div_done) begin
          cmd.div_load = 1'b1;
          state_nxt    = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: src/rpn_div.sv
module rpn_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  rpn_pkg::word_t      dividend,
  input  rpn_pkg::word_t      divisor,
  output logic                done,
  output rpn_pkg::word_t      quotient
);
  import rpn_pkg::*;

  word_t                quo_r, quo_nxt;
  word_t                rem_r, rem_nxt;
  word_t                dsr_r;
  logic                 neg_r;
  logic                 busy_r, busy_nxt;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [WORD_W:0]      shifted;
  logic [WORD_W:0]      diff;
  word_t                a_abs, b_abs;

  assign a_abs = dividend[WORD_W-1] ? (~dividend + WORD_W'(1)) : dividend;
  assign b_abs = divisor[WORD_W-1]  ? (~divisor + WORD_W'(1))  : divisor;

  assign shifted = {rem_r, quo_r[WORD_W-1]};
  assign diff    = shifted - {1'b0, dsr_r};

  always_comb begin
    if (!diff[WORD_W]) begin
      rem_nxt = diff[WORD_W-1:0];
      quo_nxt = {quo_r[WORD_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[WORD_W-1:0];
      quo_nxt = {quo_r[WORD_W-2:0], 1'b0};
    end
    busy_nxt = busy_r && (cnt_r != {DIV_CNT_W{1'b1}});
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + WORD_W'(1)) : quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= a_abs;
      rem_r <= '0;
      dsr_r <= b_abs;
      neg_r <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
      cnt_r <= '0;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= start || busy_nxt;
      done_r <= busy_r && !busy_nxt && !start;
    end
  end

endmodule

// File: src/rpn_dp.sv
module rpn_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rpn_pkg::func_t                    in_func,
  input  logic signed [rpn_pkg::WORD_W-1:0] in_value,
  input  logic                              in_last,
  output logic signed [rpn_pkg::WORD_W-1:0] out_top,
  output logic [rpn_pkg::DEPTH_OUT_W-1:0]   out_depth,
  output rpn_pkg::err_t                     out_status,
  output logic                              out_final_res,
  input  rpn_pkg::rpn_cmd_t                 cmd,
  output rpn_pkg::rpn_sts_t                 sts
);
  import rpn_pkg::*;

  word_t             mem [STACK_DEPTH];
  word_t             rd_data_r;
  word_t             tos_r;
  word_t             res_r;
  func_t             fn_r;
  word_t             val_r;
  logic              last_r;
  logic [CNT_W-1:0]  depth_r, depth_nxt;
  err_t              err_r, err_nxt;
  logic [CNT_W-1:0]  depth_m2;
  logic [PTR_W-1:0]  wr_addr;
  word_t             wr_data;
  logic              wr_en;
  word_t             prod;
  word_t             alu_res;
  word_t             quotient;
  logic              div_done;
  logic [DEXT_W-1:0] depth_ext;

  word_t             top_r;
  logic [DEPTH_OUT_W-1:0] odepth_r;
  err_t              ostatus_r;
  logic              ofinal_r;

  rpn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (rd_data_r),
    .divisor  (tos_r),
    .done     (div_done),
    .quotient (quotient)
  );

  assign depth_m2 = depth_r - CNT_W'(2);
  assign prod     = rd_data_r * tos_r;

  always_comb begin
    case (fn_r)
      FN_ADD:  alu_res = rd_data_r + tos_r;
      FN_SUB:  alu_res = rd_data_r - tos_r;
      FN_MUL:  alu_res = prod;
      default: alu_res = tos_r;
    endcase
  end

  assign sts.err_nz       = (err_r != ERR_NONE);
  assign sts.fn_push      = (fn_r == FN_PUSH);
  assign sts.fn_op        = fn_r inside {FN_ADD, FN_SUB, FN_MUL, FN_DIV};
  assign sts.fn_div       = (fn_r == FN_DIV);
  assign sts.full         = (depth_r >= CNT_W'(STACK_DEPTH));
  assign sts.under        = (depth_r < CNT_W'(2));
  assign sts.divisor_zero = (tos_r == '0);
  assign sts.div_done     = div_done;

  always_comb begin
    wr_en   = cmd.push || cmd.commit;
    wr_addr = cmd.push ? depth_r[PTR_W-1:0] : depth_m2[PTR_W-1:0];
    wr_data = cmd.push ? val_r : res_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[depth_m2[PTR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_tok) begin
      fn_r   <= in_func;
      val_r  <= in_value;
      last_r <= in_last;
    end
    if (cmd.alu_load) begin
      res_r <= alu_res;
    end else if (cmd.div_load) begin
      res_r <= quotient;
    end
    if (cmd.push) begin
      tos_r <= val_r;
    end else if (cmd.commit) begin
      tos_r <= res_r;
    end
  end

  always_comb begin
    depth_nxt = depth_r;
    err_nxt   = err_r;
    if (cmd.push) begin
      depth_nxt = depth_r + CNT_W'(1);
    end else if (cmd.commit) begin
      depth_nxt = depth_r - CNT_W'(1);
    end
    if (cmd.set_err) begin
      err_nxt = cmd.err_code;
    end
    if (cmd.out_load && last_r) begin
      depth_nxt = '0;
      err_nxt   = ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      err_r   <= ERR_NONE;
    end else begin
      depth_r <= depth_nxt;
      err_r   <= err_nxt;
    end
  end

  assign depth_ext = DEXT_W'(depth_r);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      top_r     <= (depth_r != '0) ? tos_r : '0;
      odepth_r  <= depth_ext[DEPTH_OUT_W-1:0];
      ostatus_r <= err_r;
      ofinal_r  <= last_r;
    end
  end

  assign out_top       = top_r;
  assign out_depth     = odepth_r;
  assign out_status    = ostatus_r;
  assign out_final_res = ofinal_r;

endmodule

// File: src/rpn_stack_calculator_unit.sv
// Reverse Polish evaluator over signed 32-bit words, stack of STACK_DEPTH entries.
// Input channel (in_valid/in_ready): one token per transaction; in_func selects
// push, add, subtract, multiply or divide, in_value is the number to push and
// in_last marks the final token of an expression.
// Output channel (out_valid/out_ready): one transaction per token giving the top
// of stack, the depth, the sticky status and the final flag.
// A push, an ignored token, an overflow or an underflow goes from decode straight
// to the output register; a divide by zero is caught in the operand state; add,
// subtract and multiply pass through the ALU and a commit, and divide through the
// 32-step shift-subtract divider and a commit. One token is in flight at a time
// and the controller returns to idle after each token.
// The result is held in an output register; the next token is taken while it
// waits, but a finished token waits in the controller until the receiver frees
// that register, so a stalled receiver backs up the input channel.
// Reset empties the stack and clears the error status; stack memory contents
// are left as they are and never read before being written.
module rpn_stack_calculator_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        in_func,
  input  logic signed [31:0]                in_value,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [31:0]                out_top,
  output logic [4:0]                        out_depth,
  output logic [1:0]                        out_status,
  output logic                              out_final_res
);
  import rpn_pkg::*;

  rpn_cmd_t cmd;
  rpn_sts_t sts;

  rpn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rpn_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_func       (in_func),
    .in_value      (in_value),
    .in_last       (in_last),
    .out_top       (out_top),
    .out_depth     (out_depth),
    .out_status    (out_status),
    .out_final_res (out_final_res),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

// File: tb/sv/rpn_stack_calculator_unit_checker.sv
`timescale 1ns / 1ps
module rpn_stack_calculator_unit_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [31:0] in_value,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_top,
  input  logic [4:0]  out_depth,
  input  logic [1:0]  out_status,
  input  logic        out_final_res,
  output int          fail_count,
  output int          pending
);
  import rpn_pkg::*;

  typedef struct packed {
    word_t      top;
    logic [4:0] depth;
    err_t       status;
    logic       fin;
  } stack_report_t;

  word_t         stack_mem [STACK_DEPTH];
  int            stack_cnt = 0;
  err_t          sticky_err = ERR_NONE;
  stack_report_t report_q [$];
  int            mismatches = 0;

  function automatic word_t alu_result(func_t f, word_t a, word_t b);
    longint sa;
    longint sb;
    longint q;
    sa = longint'($signed(a));
    sb = longint'($signed(b));
    case (f)
      FN_ADD: q = sa + sb;
      FN_SUB: q = sa - sb;
      FN_MUL: q = sa * sb;
      default: q = sa / sb;
    endcase
    return q[31:0];
  endfunction

  task automatic evaluate_token(func_t f, word_t v, logic l);
    stack_report_t r;
    if (sticky_err == ERR_NONE) begin
      if (f == FN_PUSH) begin
        if (stack_cnt >= STACK_DEPTH) begin
          sticky_err = ERR_OVERFLOW;
        end else begin
          stack_mem[stack_cnt] = v;
          stack_cnt++;
        end
      end else if (f <= FN_DIV) begin
        if (stack_cnt < 2) begin
          sticky_err = ERR_UNDERFLOW;
        end else if (f == FN_DIV && stack_mem[stack_cnt-1] == '0) begin
          sticky_err = ERR_DIVZERO;
        end else begin
          stack_mem[stack_cnt-2] = alu_result(f, stack_mem[stack_cnt-2],
                                              stack_mem[stack_cnt-1]);
          stack_cnt--;
        end
      end
    end
    r.top    = (stack_cnt > 0) ? stack_mem[stack_cnt-1] : '0;
    r.depth  = stack_cnt[4:0];
    r.status = sticky_err;
    r.fin    = l;
    report_q.push_back(r);
    if (l) begin
      stack_cnt  = 0;
      sticky_err = ERR_NONE;
    end
  endtask

  task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %h actual %h", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    stack_report_t exp_r;
    if (!rst_n) begin
      stack_cnt  = 0;
      sticky_err = ERR_NONE;
      report_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (report_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transaction: expected none actual top %h depth %0d status %0d final %0b",
                   $time, out_top, out_depth, out_status, out_final_res);
        end else begin
          exp_r = report_q.pop_front();
          check_field("top", exp_r.top, out_top);
          check_field("depth", 32'(exp_r.depth), 32'(out_depth));
          check_field("status", 32'(exp_r.status), 32'(out_status));
          check_field("final_res", 32'(exp_r.fin), 32'(out_final_res));
        end
      end
      if (in_valid && in_ready) begin
        evaluate_token(in_func, in_value, in_last);
      end
    end
    fail_count <= mismatches;
    pending    <= report_q.size();
  end

endmodule

// File: tb/sv/rpn_stack_calculator_unit_tb.sv
`timescale 1ns / 1ps
module rpn_stack_calculator_unit_tb;
  import rpn_pkg::*;

  localparam int    CYCLE_LIMIT    = 200000;
  localparam int    RX_HOLD_CYCLES = 300;
  localparam int    PHASE_TOKENS   = 135;
  localparam word_t INT_MIN        = 32'h8000_0000;
  localparam word_t INT_MAX        = 32'h7FFF_FFFF;

  logic         clk;
  logic         rst_n;
  logic         in_valid;
  logic         in_ready;
  logic [2:0]   in_func;
  logic [31:0]  in_value;
  logic         in_last;
  logic         out_valid;
  logic         out_ready;
  logic [31:0]  out_top;
  logic [4:0]   out_depth;
  logic [1:0]   out_status;
  logic         out_final_res;

  int fail_count;
  int pending;
  int tx_idle_pct = 18;
  int rx_idle_pct = 62;
  bit rx_hold_req = 1'b0;
  int tokens_sent = 0;
  int cycles = 0;

  rpn_stack_calculator_unit u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_value      (in_value),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_top       (out_top),
    .out_depth     (out_depth),
    .out_status    (out_status),
    .out_final_res (out_final_res)
  );

  rpn_stack_calculator_unit_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_value      (in_value),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_top       (out_top),
    .out_depth     (out_depth),
    .out_status    (out_status),
    .out_final_res (out_final_res),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin : rx_side
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        hold_left   = RX_HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom();
      4, 5, 6: return word_t'($urandom_range(0, 16)) - 32'd8;
      7: return INT_MIN;
      8: return INT_MAX;
      default: return {32{$urandom_range(0, 1) == 1}};
    endcase
  endfunction

  task automatic send_token(func_t f, word_t v, logic l);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= f;
    in_value <= v;
    in_last  <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (f <= FN_DIV) tokens_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_expression();
    int    kind;
    int    len;
    int    d;
    func_t f;
    kind = $urandom_range(0, 99);
    d    = 0;
    if (kind < 12) begin
      len = $urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 4);
      for (int i = 0; i < len; i++) begin
        f = (i <= STACK_DEPTH) ? FN_PUSH : func_t'($urandom_range(FN_ADD, FN_DIV));
        send_token(f, rand_word(), i == len - 1);
      end
    end else if (kind < 25) begin
      len = $urandom_range(1, 10);
      for (int i = 0; i < len; i++) begin
        send_token(func_t'($urandom_range(0, 7)), rand_word(),
                   (i == len - 1) || ($urandom_range(0, 3) == 0));
      end
    end else begin
      len = $urandom_range(1, 24);
      for (int i = 0; i < len; i++) begin
        if (kind < 40 && $urandom_range(0, 9) == 0) begin
          f = func_t'($urandom_range(0, 7));
        end else if (d < 2 || (d < STACK_DEPTH && $urandom_range(0, 1) == 1)) begin
          f = FN_PUSH;
        end else begin
          f = func_t'($urandom_range(FN_ADD, FN_DIV));
        end
        if (f == FN_PUSH) begin
          d++;
        end else if (f <= FN_DIV && d >= 2) begin
          d--;
        end
        send_token(f, rand_word(), i == len - 1);
      end
    end
  endtask

  initial begin : stimulus
    bit hold_done;
    hold_done = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_func   = FN_PUSH;
    in_value  = '0;
    in_last   = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_token(FN_PUSH, INT_MIN, 1'b0);
    send_token(FN_PUSH, '1, 1'b0);
    send_token(FN_DIV, $urandom(), 1'b0);
    send_token(FN_PUSH, INT_MAX, 1'b0);
    send_token(FN_ADD, $urandom(), 1'b0);
    send_token(FN_PUSH, 32'd3, 1'b0);
    send_token(FN_MUL, $urandom(), 1'b0);
    send_token(FN_PUSH, 32'd2, 1'b0);
    send_token(FN_SUB, $urandom(), 1'b0);
    send_token(FN_PUSH, '0, 1'b0);
    send_token(FN_DIV, $urandom(), 1'b0);
    send_token(FN_ADD, $urandom(), 1'b1);
    send_token(FN_ADD, $urandom(), 1'b1);
    send_token(FN_PUSH, 32'hFFFF_FFF9, 1'b0);
    send_token(FN_PUSH, 32'd2, 1'b0);
    send_token(FN_DIV, $urandom(), 1'b0);
    send_token(func_t'(5), $urandom(), 1'b0);
    send_token(func_t'(6), $urandom(), 1'b0);
    send_token(func_t'(7), $urandom(), 1'b1);
    send_token(FN_PUSH, INT_MAX, 1'b1);

    for (int p = 0; p < 3; p++) begin
      tx_idle_pct = (p == 0) ? 18 : (p == 1) ? 62 : 0;
      rx_idle_pct = (p == 0) ? 62 : (p == 1) ? 18 : 0;
      while (tokens_sent < (p + 1) * PHASE_TOKENS) begin
        if (p == 2 && !hold_done && tokens_sent >= 2 * PHASE_TOKENS + 30) begin
          rx_hold_req = 1'b1;
          hold_done   = 1'b1;
        end
        run_expression();
      end
      wait_drained();
    end

    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
